/* sv/wmed_pkg.sv */
// Shared types and constants for the window median unit.
// No dependencies; every other file of the block imports this package.
package wmed_pkg;

   localparam int WINDOW_MAX  = 32;
   localparam int SAMPLE_BITS = 24;
   // Wide enough to hold the full window size itself.
   localparam int COUNT_W     = $clog2(WINDOW_MAX + 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [COUNT_W-1:0]            count_type;

   typedef struct packed {
      sample_type sample_value;
      logic       last_sample;
   } req_type;

   typedef struct packed {
      sample_type median_value;
      count_type  window_count;
      logic       overflow_flag;
   } rsp_type;

   // One queued request, tagged by the front end with whether it fits.
   typedef struct packed {
      req_type req;
      logic    keep;
   } q_item_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic       valid;
      q_item_type item;
   } q_head_type;

endpackage

/* sv/wmed_front.sv */
// Front end of the window median unit: accepts requests, marks each one as
// stored or dropped, and holds them in a two-entry queue. Uses wmed_pkg.
module wmed_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wmed_pkg::req_type req_data,
   output wmed_pkg::q_head_type q_head,
   input  logic             q_pop
);
   import wmed_pkg::*;

   q_item_type q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] q_cnt_ff, q_cnt_in;
   count_type  win_cnt_ff, win_cnt_in;
   logic       accept;
   logic       pop;
   logic       keep;

   assign req_ready = (q_cnt_ff != 2'd2);
   assign accept    = req_valid && req_ready;
   assign pop       = q_pop && (q_cnt_ff != 2'd0);
   assign keep      = (win_cnt_ff < COUNT_W'(WINDOW_MAX));

   assign q_head.valid = (q_cnt_ff != 2'd0);
   assign q_head.item  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? ~rd_ptr_ff : rd_ptr_ff;
      q_cnt_in   = q_cnt_ff + {1'b0, accept} - {1'b0, pop};
      win_cnt_in = win_cnt_ff;
      if (accept) begin
         if (req_data.last_sample) begin
            win_cnt_in = '0;
         end else if (keep) begin
            win_cnt_in = win_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         q_cnt_ff   <= '0;
         win_cnt_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_cnt_ff   <= q_cnt_in;
         win_cnt_ff <= win_cnt_in;
      end
      if (accept) begin
         q_mem_ff[wr_ptr_ff] <= '{req: req_data, keep: keep};
      end
   end

endmodule

/* sv/wmed_sort_core.sv */
// Back end of the window median unit: insertion-sorting cell chain, drain
// sequencer that picks the middle pair, and the response register. Uses wmed_pkg.
module wmed_sort_core (
   input  logic                 clock,
   input  logic                 reset,
   input  wmed_pkg::q_head_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wmed_pkg::rsp_type    rsp_data
);
   import wmed_pkg::*;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type  state_ff;
   sample_type cell_ff [WINDOW_MAX];
   sample_type cell_in [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] gt;
   count_type  fill_ff;
   logic       drop_ff;
   count_type  step_ff;
   sample_type lo_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_data_ff;

   count_type  mid;
   logic       out_free;
   logic signed [SAMPLE_BITS:0] pair_sum;
   sample_type median;
   sample_type v;

   assign v         = q_head.item.req.sample_value;
   assign q_pop     = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mid       = fill_ff >> 1;

   // A new response is loaded in the last drain cycle; otherwise a pending one
   // stays until it is taken.
   assign rsp_valid_in = ((state_ff == ST_DRAIN) && (step_ff == mid) && out_free) ||
                         (rsp_valid_ff && !rsp_ready);

   // Each occupied cell holding a larger value moves up one place; the new
   // sample lands in the lowest cell that moved, or at the end of the row.
   always_comb begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
         gt[i] = (COUNT_W'(i) < fill_ff) && (cell_ff[i] > v);
      end
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
         end else if (gt[i] || COUNT_W'(i) == fill_ff) begin
            cell_in[i] = v;
         end else begin
            cell_in[i] = cell_ff[i];
         end
      end
   end

   // Cell 0 holds the element of rank step_ff while draining.
   always_comb begin
      pair_sum = {lo_ff[SAMPLE_BITS-1], lo_ff} + {cell_ff[0][SAMPLE_BITS-1], cell_ff[0]};
      median   = fill_ff[0] ? cell_ff[0] : pair_sum[SAMPLE_BITS:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_LOAD: begin
               if (q_head.valid) begin
                  if (q_head.item.keep) begin
                     cell_ff <= cell_in;
                     fill_ff <= fill_ff + 1'b1;
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (q_head.item.req.last_sample) begin
                     step_ff  <= '0;
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               if (step_ff != mid) begin
                  if (step_ff == mid - 1'b1) begin
                     lo_ff <= cell_ff[0];
                  end
                  for (int i = 0; i < WINDOW_MAX - 1; i++) begin
                     cell_ff[i] <= cell_ff[i+1];
                  end
                  step_ff <= step_ff + 1'b1;
               end else if (out_free) begin
                  rsp_data_ff.median_value  <= median;
                  rsp_data_ff.window_count  <= fill_ff;
                  rsp_data_ff.overflow_flag <= drop_ff;
                  fill_ff                   <= '0;
                  drop_ff                   <= 1'b0;
                  state_ff                  <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

endmodule

/* sv/window_median_unit.sv */
// Top level of the window median unit: front end queue plus sorting back end.
// Depends on wmed_pkg, wmed_front and wmed_sort_core.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (rsp_type)
//
// Accepted samples are written to the request queue and move from it into the insertion
// cell chain, one per cycle while the back end is loading. After a marked sample, the
// chain shifts down to reach the middle pair and then loads the response register;
// meanwhile the two-entry request queue takes up to two more requests, then holds req_ready low.
// Reset is synchronous and active high; it empties the queue and the window.
// A stalled response holds the back end in its last drain cycle; requests enter
// the queue until it is full.
module window_median_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wmed_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wmed_pkg::rsp_type rsp_data
);
   import wmed_pkg::*;

   q_head_type q_head;
   logic       q_pop;

   wmed_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   wmed_sort_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/wmed_checker.sv */
// Port-level checks for the window median unit, bound to its top level.
// Depends on wmed_pkg and window_median_unit.
module wmed_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input wmed_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wmed_pkg::rsp_type rsp_data
);
   import wmed_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.window_count != '0 &&
                    rsp_data.window_count <= COUNT_W'(WINDOW_MAX))
      else $error("window count out of range");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow_flag |-> rsp_data.window_count == COUNT_W'(WINDOW_MAX))
      else $error("overflow reported on a window that was not full");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending right after reset");

endmodule

bind window_median_unit wmed_checker u_wmed_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
